/* hdl/ssprx_pkg.sv */
//------------------------------------------------------------------------------
// ssprx_pkg
// Shared types and codes for the servo status packet receiver: operation
// and result kind codes, the input item and the result item.
//------------------------------------------------------------------------------
`default_nettype none

package ssprx_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result kind codes.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Reset value of the sync byte register.
	localparam logic [7:0] HEADER_RESET = 8'hFF;

	// One input item.
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
		logic [7:0] expected_id;
		logic [7:0] expected_data_count;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic [7:0] device_error;
		logic [7:0] received_id;
		logic       timed_out;
		logic       header_error;
		logic       id_mismatch;
		logic       length_mismatch;
		logic       checksum_error;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

/* hdl/ssprx_fsm.sv */
//------------------------------------------------------------------------------
// ssprx_fsm
// Packet state machine. Looks at the registered input item, computes the
// result it causes and updates the packet state when the item is consumed.
//------------------------------------------------------------------------------
`default_nettype none

module ssprx_fsm
	import ssprx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] header_byte,
	input  wire item_t      item,
	input  wire logic       step_en,
	output logic            has_result,
	output result_t         result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HUNT  = 3'd1,
		PH_HDR2  = 3'd2,
		PH_ID    = 3'd3,
		PH_LEN   = 3'd4,
		PH_ERR   = 3'd5,
		PH_PARAM = 3'd6,
		PH_CSUM  = 3'd7
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] want_id_q, want_id_d;
	logic [7:0] want_count_q, want_count_d;
	logic [7:0] got_id_q, got_id_d;
	logic [7:0] got_length_q, got_length_d;
	logic [7:0] got_error_q, got_error_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] count_q, count_d;

	logic [7:0] sum_plus;
	logic [7:0] count_plus;
	logic [7:0] params_total;
	logic [8:0] length_expect;
	result_t    status;

	// Running byte sum, parameter counter and the length compare operands.
	assign sum_plus      = sum_q + item.rx_byte;
	assign count_plus    = count_q + 8'd1;
	assign params_total  = got_length_q - 8'd2;
	assign length_expect = {1'b0, want_count_q} + 9'd2;

	// Status result carrying what has been received so far; flags are set per case.
	always_comb begin
		status              = '0;
		status.kind         = KIND_STATUS;
		status.device_error = got_error_q;
		status.received_id  = got_id_q;
		status.last         = 1'b1;
	end

	// Next state and result for the item at hand.
	always_comb begin
		phase_d      = phase_q;
		want_id_d    = want_id_q;
		want_count_d = want_count_q;
		got_id_d     = got_id_q;
		got_length_d = got_length_q;
		got_error_d  = got_error_q;
		sum_d        = sum_q;
		count_d      = count_q;
		has_result   = 1'b0;
		result       = '0;

		unique case (item.operation)
			OP_START: begin
				want_id_d    = item.expected_id;
				want_count_d = item.expected_data_count;
				got_id_d     = '0;
				got_length_d = '0;
				got_error_d  = '0;
				sum_d        = '0;
				count_d      = '0;
				phase_d      = PH_HUNT;
			end
			OP_TIMEOUT: begin
				if (phase_q != PH_IDLE) begin
					has_result       = 1'b1;
					result           = status;
					result.timed_out = 1'b1;
					phase_d          = PH_IDLE;
				end
			end
			OP_BYTE: begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_HUNT: begin
						if (item.rx_byte == header_byte) begin
							phase_d = PH_HDR2;
						end
					end
					PH_HDR2: begin
						if (item.rx_byte != header_byte) begin
							has_result          = 1'b1;
							result              = status;
							result.header_error = 1'b1;
							phase_d             = PH_IDLE;
						end else begin
							phase_d = PH_ID;
						end
					end
					PH_ID: begin
						got_id_d = item.rx_byte;
						sum_d    = item.rx_byte;
						phase_d  = PH_LEN;
					end
					PH_LEN: begin
						got_length_d = item.rx_byte;
						sum_d        = sum_plus;
						phase_d      = PH_ERR;
					end
					PH_ERR: begin
						got_error_d = item.rx_byte;
						sum_d       = sum_plus;
						count_d     = '0;
						phase_d     = (got_length_q > 8'd2) ? PH_PARAM : PH_CSUM;
					end
					PH_PARAM: begin
						has_result        = 1'b1;
						result.kind       = KIND_DATA;
						result.data_byte  = item.rx_byte;
						result.data_index = count_q;
						sum_d             = sum_plus;
						count_d           = count_plus;
						if (count_plus >= params_total) begin
							phase_d = PH_CSUM;
						end
					end
					PH_CSUM: begin
						has_result             = 1'b1;
						result                 = status;
						result.id_mismatch     = (got_id_q != want_id_q);
						result.length_mismatch = ({1'b0, got_length_q} != length_expect);
						result.checksum_error  = (item.rx_byte != ~sum_q);
						phase_d                = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Packet state, updated only when the item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			want_id_q    <= '0;
			want_count_q <= '0;
			got_id_q     <= '0;
			got_length_q <= '0;
			got_error_q  <= '0;
			sum_q        <= '0;
			count_q      <= '0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			want_id_q    <= want_id_d;
			want_count_q <= want_count_d;
			got_id_q     <= got_id_d;
			got_length_q <= got_length_d;
			got_error_q  <= got_error_d;
			sum_q        <= sum_d;
			count_q      <= count_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/servo_status_packet_receiver_core.sv */
// An accepted input beat waits in the input register; its result is valid once written to the result register.
// Throughput: one input beat per cycle; the packet state machine handles
// one beat per cycle between the input register and the result register.
// A waiting result stalls only beats that produce a result.
// Reset: asynchronous, active low; idle state, sync byte back to 0xFF.
//------------------------------------------------------------------------------
// servo_status_packet_receiver_core
// Top level: input register, packet state machine, result register and the
// sync byte configuration register.
//------------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_receiver_core
	import ssprx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] expected_id,
	input  wire logic [7:0] expected_data_count,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic [7:0]      data_index,
	output logic [7:0]      device_error,
	output logic [7:0]      received_id,
	output logic            timed_out,
	output logic            header_error,
	output logic            id_mismatch,
	output logic            length_mismatch,
	output logic            checksum_error,
	output logic            last
);

	logic [7:0] header_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    result_s2;
	logic       has_result;
	result_t    result;
	logic       advance;

	// Sync byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_wr_en) begin
			header_q <= cfg_wr_data;
		end
	end

	// The registered beat moves on unless its result would find the output full.
	assign advance  = valid_s1 && (!has_result || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_ready && in_valid) begin
			item_s1.operation           <= operation;
			item_s1.rx_byte             <= rx_byte;
			item_s1.expected_id         <= expected_id;
			item_s1.expected_data_count <= expected_data_count;
		end
	end

	ssprx_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_byte (header_q),
		.item        (item_s1),
		.step_en     (advance),
		.has_result  (has_result),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_s2 <= result;
		end
	end

	// Output ports.
	assign out_valid       = valid_s2;
	assign kind            = result_s2.kind;
	assign data_byte       = result_s2.data_byte;
	assign data_index      = result_s2.data_index;
	assign device_error    = result_s2.device_error;
	assign received_id     = result_s2.received_id;
	assign timed_out       = result_s2.timed_out;
	assign header_error    = result_s2.header_error;
	assign id_mismatch     = result_s2.id_mismatch;
	assign length_mismatch = result_s2.length_mismatch;
	assign checksum_error  = result_s2.checksum_error;
	assign last            = result_s2.last;

endmodule

`default_nettype wire
